/* src/vnig_pkg.sv */
// shared types, constants and helper functions of the voxel neighbor index generator
`timescale 1ns / 1ps

package vnig_pkg;

   localparam int IDX_W              = 27;
   localparam int CFG_W              = 10;
   localparam int MODE_W             = 2;
   localparam int CSR_IDX_W          = 2;
   localparam int NPOS               = 27;
   localparam int DEFAULT_MAX_EXTENT = 512;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE,
      MODE_SIX,
      MODE_EIGHTEEN,
      MODE_TWENTY_SIX
   } conn_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_SIZE_X,
      CSR_SIZE_Y,
      CSR_SIZE_Z
   } csr_index_type;

   typedef struct packed {
      conn_mode_type    mode;
      logic [CFG_W-1:0] size_x;
      logic [CFG_W-1:0] size_y;
      logic [CFG_W-1:0] size_z;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:   MODE_NONE,
      size_x: CFG_W'(1),
      size_y: CFG_W'(1),
      size_z: CFG_W'(1)
   };

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_PLANE,
      FRONT_VOLUME,
      FRONT_DIV_Z,
      FRONT_DIV_Y,
      FRONT_MASK,
      FRONT_PUSH
   } front_state_type;

   // n is the number of nonzero offset components
   function automatic logic conn_allowed(conn_mode_type mode, int n);
      case (mode)
         MODE_SIX:        return n == 1;
         MODE_EIGHTEEN:   return (n == 1) || (n == 2);
         MODE_TWENTY_SIX: return n >= 1;
         default:         return 1'b0;
      endcase
   endfunction

   // two's complement code of an offset of -1, 0 or 1
   function automatic logic [1:0] off_code(int d);
      if (d == 1) begin
         return 2'b01;
      end
      if (d == -1) begin
         return 2'b11;
      end
      return 2'b00;
   endfunction

endpackage

/* src/voxel_neighbor_index_generator_top.sv */
// top level of the voxel neighbor index generator with its configuration registers
`timescale 1ns / 1ps

// Input items (req_voxel_index) are pushed with req_push while req_full is low.
// Result items come out oldest first while rsp_empty is low and leave on rsp_pop.
// Configuration: csr_write with csr_index 0 mode, 1 size_x, 2 size_y, 3 size_z.
// The front splits the index into coordinates with a shared shift-subtract
// divider, one quotient bit a cycle; an out-of-grid item skips the divider.
// A one-item input buffer takes the next item while the current one is split.
// A two-entry job queue sits between front and back, so either side stalls alone.
// The back emits one result item a cycle from the neighbor mask while the
// output register is free, up to 26 per input item, or one found=0 item for an
// empty run.
// When rsp_pop stays low the output register, back and queue fill, then the
// front holds its job and req_full rises.
// Reset (synchronous, active high) empties all stages and sets mode 0 and all
// grid extents to 1.

module voxel_neighbor_index_generator_top #(
   parameter int MAX_EXTENT = vnig_pkg::DEFAULT_MAX_EXTENT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [vnig_pkg::IDX_W-1:0]     req_voxel_index,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [vnig_pkg::IDX_W-1:0]     rsp_neighbor_index,
   output logic signed [1:0]              rsp_offset_x,
   output logic signed [1:0]              rsp_offset_y,
   output logic signed [1:0]              rsp_offset_z,
   output logic                           rsp_found,
   output logic                           rsp_index_in_range,
   output logic                           rsp_last,
   input  logic                           csr_write,
   input  logic [vnig_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vnig_pkg::CFG_W-1:0]     csr_data
);
   import vnig_pkg::*;

   localparam int EXT_W   = $clog2(MAX_EXTENT + 1);
   localparam int PLANE_W = 2 * EXT_W;
   localparam int JOB_W   = IDX_W + EXT_W + PLANE_W + NPOS + 1;

   cfg_type cfg_ff, cfg_in;

   logic             fq_valid, fq_ready;
   logic [JOB_W-1:0] fq_data;
   logic             qb_valid, qb_ready;
   logic [JOB_W-1:0] qb_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:   cfg_in.mode   = conn_mode_type'(csr_data[MODE_W-1:0]);
            CSR_SIZE_X: cfg_in.size_x = csr_data;
            CSR_SIZE_Y: cfg_in.size_y = csr_data;
            CSR_SIZE_Z: cfg_in.size_z = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vnig_front #(
      .MAX_EXTENT(MAX_EXTENT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_voxel_index (req_voxel_index),
      .req_full        (req_full),
      .job_valid       (fq_valid),
      .job_data        (fq_data),
      .job_ready       (fq_ready)
   );

   vnig_queue #(
      .WIDTH(JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_data   (fq_data),
      .in_ready  (fq_ready),
      .out_valid (qb_valid),
      .out_data  (qb_data),
      .out_ready (qb_ready)
   );

   vnig_back #(
      .MAX_EXTENT(MAX_EXTENT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (qb_valid),
      .job_data           (qb_data),
      .job_ready          (qb_ready),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_offset_x       (rsp_offset_x),
      .rsp_offset_y       (rsp_offset_y),
      .rsp_offset_z       (rsp_offset_z),
      .rsp_found          (rsp_found),
      .rsp_index_in_range (rsp_index_in_range),
      .rsp_last           (rsp_last)
   );

endmodule

/* src/vnig_queue.sv */
// short queue of classified jobs between the front and the back
`timescale 1ns / 1ps

module vnig_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             in_ready,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_ready
);
   import vnig_pkg::*;

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_ready && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* src/vnig_front.sv */
// front: takes voxel indexes, splits them into coordinates and builds the neighbor mask
`timescale 1ns / 1ps

module vnig_front #(
   parameter  int MAX_EXTENT = vnig_pkg::DEFAULT_MAX_EXTENT,
   localparam int EXT_W      = $clog2(MAX_EXTENT + 1),
   localparam int PLANE_W    = 2 * EXT_W,
   localparam int JOB_W      = vnig_pkg::IDX_W + EXT_W + PLANE_W + vnig_pkg::NPOS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  vnig_pkg::cfg_type          cfg,
   input  logic                       req_push,
   input  logic [vnig_pkg::IDX_W-1:0] req_voxel_index,
   output logic                       req_full,
   output logic                       job_valid,
   output logic [JOB_W-1:0]           job_data,
   input  logic                       job_ready
);
   import vnig_pkg::*;

   localparam int SH_W  = PLANE_W + EXT_W - 1;
   localparam int CMP_W = (SH_W > IDX_W) ? SH_W : IDX_W;
   localparam int VOL_W = PLANE_W + EXT_W;
   localparam int G_W   = (VOL_W > IDX_W) ? VOL_W : IDX_W;
   localparam int CNT_W = $clog2(EXT_W);
   localparam int CL_W  = (CFG_W > EXT_W) ? CFG_W : EXT_W;

   front_state_type state_ff, state_in;

   logic             buf_valid_ff, buf_valid_in;
   logic [IDX_W-1:0] buf_idx_ff, buf_idx_in;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic               inr_ff, inr_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [SH_W-1:0]    div_sh_ff, div_sh_in;
   logic [EXT_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [EXT_W-1:0]   cz_ff, cz_in;
   logic [EXT_W-1:0]   cy_ff, cy_in;
   logic [NPOS-1:0]    mask_ff, mask_in;

   logic [EXT_W-1:0] sxc, syc, szc;
   logic [VOL_W-1:0] volume;
   logic             in_grid;
   logic             take;
   logic             step_ge;
   logic [IDX_W-1:0] rem_next;
   logic [EXT_W-1:0] quot_next;
   logic             step_done;
   logic [EXT_W-1:0] cx;
   logic             x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
   logic [NPOS-1:0]  mask_calc;

   // extents above the limit are taken as the limit
   function automatic logic [EXT_W-1:0] clamp(logic [CFG_W-1:0] v);
      logic [CL_W-1:0] ext;
      ext = CL_W'(v);
      if (ext > CL_W'(MAX_EXTENT)) begin
         ext = CL_W'(MAX_EXTENT);
      end
      return EXT_W'(ext);
   endfunction

   assign sxc = clamp(cfg.size_x);
   assign syc = clamp(cfg.size_y);
   assign szc = clamp(cfg.size_z);

   assign req_full = buf_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (buf_valid_ff) begin
               state_in = FRONT_PLANE;
            end
         end
         FRONT_PLANE: begin
            state_in = FRONT_VOLUME;
         end
         FRONT_VOLUME: begin
            state_in = in_grid ? FRONT_DIV_Z : FRONT_PUSH;
         end
         FRONT_DIV_Z: begin
            if (step_done) begin
               state_in = FRONT_DIV_Y;
            end
         end
         FRONT_DIV_Y: begin
            if (step_done) begin
               state_in = FRONT_MASK;
            end
         end
         FRONT_MASK: begin
            state_in = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            if (job_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      take      = 1'b0;
      job_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: take      = buf_valid_ff;
         FRONT_PUSH: job_valid = 1'b1;
         default: ;
      endcase
   end

   // one-item input buffer so the next item waits while this one is split
   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_idx_in   = buf_idx_ff;
      if (req_push && !req_full) begin
         buf_valid_in = 1'b1;
         buf_idx_in   = req_voxel_index;
      end else if (take) begin
         buf_valid_in = 1'b0;
      end
   end

   assign volume  = VOL_W'(plane_ff * szc);
   assign in_grid = G_W'(idx_ff) < G_W'(volume);

   // restoring divider step, one quotient bit a cycle
   assign step_ge   = CMP_W'(rem_ff) >= CMP_W'(div_sh_ff);
   assign rem_next  = step_ge ? IDX_W'(CMP_W'(rem_ff) - CMP_W'(div_sh_ff)) : rem_ff;
   assign quot_next = {quot_ff[EXT_W-2:0], step_ge};
   assign step_done = cnt_ff == CNT_W'(EXT_W - 1);

   assign cx   = rem_ff[EXT_W-1:0];
   assign x_lo = cx != '0;
   assign y_lo = cy_ff != '0;
   assign z_lo = cz_ff != '0;
   assign x_hi = ({1'b0, cx} + (EXT_W + 1)'(1)) < {1'b0, sxc};
   assign y_hi = ({1'b0, cy_ff} + (EXT_W + 1)'(1)) < {1'b0, syc};
   assign z_hi = ({1'b0, cz_ff} + (EXT_W + 1)'(1)) < {1'b0, szc};

   // walk position p = (dz+1)*9 + (dy+1)*3 + (dx+1)
   always_comb begin
      int dx, dy, dz, n;
      logic ok_x, ok_y, ok_z;
      for (int p = 0; p < NPOS; p++) begin
         dx = (p % 3) - 1;
         dy = ((p / 3) % 3) - 1;
         dz = (p / 9) - 1;
         n  = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
         ok_x = (dx == -1) ? x_lo : (dx == 1) ? x_hi : 1'b1;
         ok_y = (dy == -1) ? y_lo : (dy == 1) ? y_hi : 1'b1;
         ok_z = (dz == -1) ? z_lo : (dz == 1) ? z_hi : 1'b1;
         mask_calc[p] = conn_allowed(cfg.mode, n) && ok_x && ok_y && ok_z;
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      plane_in  = plane_ff;
      inr_in    = inr_ff;
      rem_in    = rem_ff;
      div_sh_in = div_sh_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      cz_in     = cz_ff;
      cy_in     = cy_ff;
      mask_in   = mask_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (take) begin
               idx_in = buf_idx_ff;
            end
         end
         FRONT_PLANE: begin
            plane_in = PLANE_W'(sxc * syc);
         end
         FRONT_VOLUME: begin
            inr_in    = in_grid;
            rem_in    = idx_ff;
            div_sh_in = SH_W'(plane_ff) << (EXT_W - 1);
            quot_in   = '0;
            cnt_in    = '0;
            mask_in   = '0;
         end
         FRONT_DIV_Z: begin
            rem_in    = rem_next;
            quot_in   = quot_next;
            cnt_in    = cnt_ff + CNT_W'(1);
            div_sh_in = div_sh_ff >> 1;
            if (step_done) begin
               // z done, the remainder now splits by size_x
               cz_in     = quot_next;
               quot_in   = '0;
               cnt_in    = '0;
               div_sh_in = SH_W'(sxc) << (EXT_W - 1);
            end
         end
         FRONT_DIV_Y: begin
            rem_in    = rem_next;
            quot_in   = quot_next;
            cnt_in    = cnt_ff + CNT_W'(1);
            div_sh_in = div_sh_ff >> 1;
            if (step_done) begin
               cy_in = quot_next;
            end
         end
         FRONT_MASK: begin
            mask_in = mask_calc;
         end
         default: ;
      endcase
   end

   assign job_data = {inr_ff, mask_ff, plane_ff, sxc, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FRONT_IDLE;
         buf_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_idx_ff <= buf_idx_in;
      idx_ff     <= idx_in;
      plane_ff   <= plane_in;
      inr_ff     <= inr_in;
      rem_ff     <= rem_in;
      div_sh_ff  <= div_sh_in;
      quot_ff    <= quot_in;
      cnt_ff     <= cnt_in;
      cz_ff      <= cz_in;
      cy_ff      <= cy_in;
      mask_ff    <= mask_in;
   end

endmodule

/* src/vnig_back.sv */
// back: walks each job's neighbor mask, one result a cycle unless stalled
`timescale 1ns / 1ps

module vnig_back #(
   parameter  int MAX_EXTENT = vnig_pkg::DEFAULT_MAX_EXTENT,
   localparam int EXT_W      = $clog2(MAX_EXTENT + 1),
   localparam int PLANE_W    = 2 * EXT_W,
   localparam int JOB_W      = vnig_pkg::IDX_W + EXT_W + PLANE_W + vnig_pkg::NPOS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  logic [JOB_W-1:0]           job_data,
   output logic                       job_ready,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [vnig_pkg::IDX_W-1:0] rsp_neighbor_index,
   output logic signed [1:0]          rsp_offset_x,
   output logic signed [1:0]          rsp_offset_y,
   output logic signed [1:0]          rsp_offset_z,
   output logic                       rsp_found,
   output logic                       rsp_index_in_range,
   output logic                       rsp_last
);
   import vnig_pkg::*;

   localparam int SUM_W = ((PLANE_W > IDX_W) ? PLANE_W : IDX_W) + 2;

   logic               cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [EXT_W-1:0]   cur_sx_ff, cur_sx_in;
   logic [PLANE_W-1:0] cur_plane_ff, cur_plane_in;
   logic               cur_inr_ff, cur_inr_in;
   logic [NPOS-1:0]    rem_mask_ff, rem_mask_in;

   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [1:0]       out_ox_ff, out_ox_in;
   logic [1:0]       out_oy_ff, out_oy_in;
   logic [1:0]       out_oz_ff, out_oz_in;
   logic             out_found_ff, out_found_in;
   logic             out_inr_ff, out_inr_in;
   logic             out_last_ff, out_last_in;

   logic [IDX_W-1:0]   j_idx;
   logic [EXT_W-1:0]   j_sx;
   logic [PLANE_W-1:0] j_plane;
   logic [NPOS-1:0]    j_mask;
   logic               j_inr;

   logic [NPOS-1:0]  hit_low, rest_mask;
   logic             has_hit;
   logic [1:0]       ox, oy, oz;
   logic [SUM_W-1:0] tx, ty, tz, nsum;
   logic             out_free, advance, at_end, finish, job_take;

   assign j_idx   = job_data[IDX_W-1:0];
   assign j_sx    = job_data[IDX_W +: EXT_W];
   assign j_plane = job_data[IDX_W + EXT_W +: PLANE_W];
   assign j_mask  = job_data[IDX_W + EXT_W + PLANE_W +: NPOS];
   assign j_inr   = job_data[JOB_W-1];

   // lowest remaining neighbor in walk order
   assign hit_low   = rem_mask_ff & (~rem_mask_ff + NPOS'(1));
   assign rest_mask = rem_mask_ff & (rem_mask_ff - NPOS'(1));
   assign has_hit   = rem_mask_ff != '0;

   always_comb begin
      ox = 2'b00;
      oy = 2'b00;
      oz = 2'b00;
      for (int p = 0; p < NPOS; p++) begin
         if (hit_low[p]) begin
            ox = ox | off_code((p % 3) - 1);
            oy = oy | off_code(((p / 3) % 3) - 1);
            oz = oz | off_code((p / 9) - 1);
         end
      end
   end

   // neighbor = centre + dx + dy*size_x + dz*plane, modulo the sum width
   always_comb begin
      tx = (ox == 2'b01) ? SUM_W'(1) : (ox == 2'b11) ? {SUM_W{1'b1}} : '0;
      ty = (oy == 2'b01) ? SUM_W'(cur_sx_ff)
         : (oy == 2'b11) ? SUM_W'(0) - SUM_W'(cur_sx_ff) : '0;
      tz = (oz == 2'b01) ? SUM_W'(cur_plane_ff)
         : (oz == 2'b11) ? SUM_W'(0) - SUM_W'(cur_plane_ff) : '0;
      nsum = SUM_W'(cur_idx_ff) + tx + ty + tz;
   end

   assign out_free  = !out_valid_ff || rsp_pop;
   assign advance   = cur_valid_ff && out_free;
   assign at_end    = !has_hit || (rest_mask == '0);
   assign finish    = advance && at_end;
   assign job_take  = job_valid && (!cur_valid_ff || finish);
   assign job_ready = !cur_valid_ff || finish;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_idx_in   = cur_idx_ff;
      cur_sx_in    = cur_sx_ff;
      cur_plane_in = cur_plane_ff;
      cur_inr_in   = cur_inr_ff;
      rem_mask_in  = rem_mask_ff;
      if (job_take) begin
         cur_valid_in = 1'b1;
         cur_idx_in   = j_idx;
         cur_sx_in    = j_sx;
         cur_plane_in = j_plane;
         cur_inr_in   = j_inr;
         rem_mask_in  = j_mask;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (advance) begin
         rem_mask_in = rest_mask;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_ox_in    = out_ox_ff;
      out_oy_in    = out_oy_ff;
      out_oz_in    = out_oz_ff;
      out_found_in = out_found_ff;
      out_inr_in   = out_inr_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         // an empty mask gives the single found=0 item
         out_valid_in = 1'b1;
         out_idx_in   = has_hit ? IDX_W'(nsum) : '0;
         out_ox_in    = ox;
         out_oy_in    = oy;
         out_oz_in    = oz;
         out_found_in = has_hit;
         out_inr_in   = cur_inr_ff;
         out_last_in  = at_end;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_neighbor_index = out_idx_ff;
   assign rsp_offset_x       = $signed(out_ox_ff);
   assign rsp_offset_y       = $signed(out_oy_ff);
   assign rsp_offset_z       = $signed(out_oz_ff);
   assign rsp_found          = out_found_ff;
   assign rsp_index_in_range = out_inr_ff;
   assign rsp_last           = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff   <= cur_idx_in;
      cur_sx_ff    <= cur_sx_in;
      cur_plane_ff <= cur_plane_in;
      cur_inr_ff   <= cur_inr_in;
      rem_mask_ff  <= rem_mask_in;
      out_idx_ff   <= out_idx_in;
      out_ox_ff    <= out_ox_in;
      out_oy_ff    <= out_oy_in;
      out_oz_ff    <= out_oz_in;
      out_found_ff <= out_found_in;
      out_inr_ff   <= out_inr_in;
      out_last_ff  <= out_last_in;
   end

endmodule
